@@ src/usgc_pkg.sv @@
package usgc_pkg;

	typedef enum logic [2:0] {
		MODE_CHECK_PTS  = 3'd0,
		MODE_ADV_PTS    = 3'd1,
		MODE_SET_CHAN   = 3'd2,
		MODE_FORGET     = 3'd3,
		MODE_CHECK_SEQ  = 3'd4,
		MODE_ADV_SEQ    = 3'd5,
		MODE_RESET      = 3'd6,
		MODE_CLEAR      = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		VERDICT_APPLY     = 2'd0,
		VERDICT_DUPLICATE = 2'd1,
		VERDICT_GAP       = 2'd2,
		VERDICT_IGNORE    = 2'd3
	} verdict_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_READ,
		ST_EXEC
	} state_t;

	localparam int unsigned KeyW = 63;
	localparam int unsigned CntW = 32;

	typedef struct packed {
		logic load;
		logic lookup;
		logic read;
		logic exec;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

endpackage

@@ src/usgc_if.sv @@
interface usgc_req_if;
	logic                              valid;
	logic                              ready;
	logic [2:0]                        mode;
	logic [usgc_pkg::KeyW-1:0]         chan_key;
	logic signed [usgc_pkg::CntW-1:0]  pts;
	logic signed [usgc_pkg::CntW-1:0]  pts_step;
	logic signed [usgc_pkg::CntW-1:0]  seq_first;
	logic signed [usgc_pkg::CntW-1:0]  seq;
	logic signed [usgc_pkg::CntW-1:0]  date;

	modport source (output valid, mode, chan_key, pts, pts_step, seq_first, seq, date,
		input ready);
	modport sink (input valid, mode, chan_key, pts, pts_step, seq_first, seq, date,
		output ready);
endinterface

interface usgc_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [1:0]                        verdict;
	logic signed [usgc_pkg::CntW-1:0]  local_pts;
	logic                              known;
	logic                              state_valid;
	logic                              table_full;

	modport source (output valid, verdict, local_pts, known, state_valid, table_full,
		input ready);
	modport sink (input valid, verdict, local_pts, known, state_valid, table_full,
		output ready);
endinterface

@@ src/update_sequence_gap_checker.sv @@
// Each request word is handled in steps: the word is registered, its channel key is
// matched against every table entry held in flip-flops, the matching counter is read from
// the counter memory through its registered read port, and then the verdict is decided,
// the counters and table are updated and the result word is loaded into the output
// register. The next request is taken in the cycle after that, so no new word enters
// until the last result is loaded; a result that is not taken holds the decision step
// until the output register frees. No clearing pass follows reset.
module update_sequence_gap_checker #(
	parameter int unsigned CHANNEL_ENTRIES = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	usgc_req_if.sink   req,
	usgc_rsp_if.source rsp
);

	usgc_pkg::cmd_t    cmd;
	usgc_pkg::status_t status;
	logic              req_ready;

	assign req.ready = req_ready;

	usgc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.status    (status),
		.cmd       (cmd)
	);

	usgc_dp #(
		.CHANNEL_ENTRIES (CHANNEL_ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.mode      (req.mode),
		.chan_key  (req.chan_key),
		.pts       (req.pts),
		.pts_step  (req.pts_step),
		.seq_first (req.seq_first),
		.seq       (req.seq),
		.date      (req.date),
		.rsp       (rsp)
	);

endmodule

@@ src/usgc_ctrl.sv @@
module usgc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  usgc_pkg::status_t  status,
	output usgc_pkg::cmd_t     cmd
);

	usgc_pkg::state_t state_q;
	usgc_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= usgc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		req_ready  = 1'b0;
		case (state_q)
			usgc_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = usgc_pkg::ST_LOOKUP;
				end
			end
			usgc_pkg::ST_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_d    = usgc_pkg::ST_READ;
			end
			usgc_pkg::ST_READ: begin
				cmd.read = 1'b1;
				state_d  = usgc_pkg::ST_EXEC;
			end
			usgc_pkg::ST_EXEC: begin
				if (status.out_free) begin
					cmd.exec = 1'b1;
					state_d  = usgc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = usgc_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

@@ src/usgc_dp.sv @@
module usgc_dp #(
	parameter int unsigned CHANNEL_ENTRIES = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  usgc_pkg::cmd_t                    cmd,
	output usgc_pkg::status_t                 status,
	input  logic [2:0]                        mode,
	input  logic [usgc_pkg::KeyW-1:0]         chan_key,
	input  logic signed [usgc_pkg::CntW-1:0]  pts,
	input  logic signed [usgc_pkg::CntW-1:0]  pts_step,
	input  logic signed [usgc_pkg::CntW-1:0]  seq_first,
	input  logic signed [usgc_pkg::CntW-1:0]  seq,
	input  logic signed [usgc_pkg::CntW-1:0]  date,
	usgc_rsp_if.source                        rsp
);

	localparam int unsigned IdxW = (CHANNEL_ENTRIES > 1) ? $clog2(CHANNEL_ENTRIES) : 1;

	// Latched request word.
	usgc_pkg::mode_t                   mode_q;
	logic [usgc_pkg::KeyW-1:0]         key_q;
	logic signed [usgc_pkg::CntW-1:0]  pts_q;
	logic signed [usgc_pkg::CntW-1:0]  cnt_q;
	logic signed [usgc_pkg::CntW-1:0]  sstart_q;
	logic signed [usgc_pkg::CntW-1:0]  seq_q;
	logic signed [usgc_pkg::CntW-1:0]  date_q;

	// Common counters.
	logic signed [usgc_pkg::CntW-1:0]  common_pts_q;
	logic signed [usgc_pkg::CntW-1:0]  common_seq_q;
	logic signed [usgc_pkg::CntW-1:0]  last_date_q;
	logic                              counters_set_q;

	// Channel table: keys and valid bits in flip-flops, counters in a memory.
	logic [CHANNEL_ENTRIES-1:0]        used_q;
	logic [usgc_pkg::KeyW-1:0]         key_tab_q [CHANNEL_ENTRIES];
	logic [usgc_pkg::CntW-1:0]         pts_mem [CHANNEL_ENTRIES];

	logic [IdxW-1:0]                   match_idx_q;
	logic                              hit_q;
	logic [IdxW-1:0]                   free_idx_q;
	logic                              free_ok_q;
	logic signed [usgc_pkg::CntW-1:0]  rd_pts_q;

	logic [IdxW-1:0]                   match_idx;
	logic                              match_any;
	logic [IdxW-1:0]                   free_idx;
	logic                              free_any;

	// Output register.
	logic                              out_valid_q;
	logic [1:0]                        verdict_q;
	logic signed [usgc_pkg::CntW-1:0]  local_q;
	logic                              known_q;
	logic                              state_valid_q;
	logic                              full_q;

	// Decision signals.
	logic                              key_nz;
	logic signed [usgc_pkg::CntW-1:0]  local_pre;
	logic signed [usgc_pkg::CntW-1:0]  sstart_eff;
	usgc_pkg::verdict_t                verdict;
	logic                              store_req;
	logic                              store_ok;
	logic                              full;
	logic                              mem_we;
	logic [IdxW-1:0]                   mem_addr;
	logic                              forget_hit;
	logic signed [usgc_pkg::CntW-1:0]  common_pts_d;
	logic signed [usgc_pkg::CntW-1:0]  common_seq_d;
	logic signed [usgc_pkg::CntW-1:0]  last_date_d;
	logic                              counters_set_d;
	logic signed [usgc_pkg::CntW-1:0]  local_post;
	logic                              known_post;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q   <= usgc_pkg::mode_t'(mode);
			key_q    <= chan_key;
			pts_q    <= pts;
			cnt_q    <= pts_step;
			sstart_q <= seq_first;
			seq_q    <= seq;
			date_q   <= date;
		end
	end

	always_comb begin
		match_idx = '0;
		match_any = 1'b0;
		free_idx  = '0;
		free_any  = 1'b0;
		for (int i = 0; i < CHANNEL_ENTRIES; i++) begin
			if (!match_any && used_q[i] && key_tab_q[i] == key_q) begin
				match_any = 1'b1;
				match_idx = IdxW'(i);
			end
			if (!free_any && !used_q[i]) begin
				free_any = 1'b1;
				free_idx = IdxW'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (cmd.lookup) begin
			hit_q <= match_any && (key_q != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			match_idx_q <= match_idx;
			free_idx_q  <= free_idx;
			free_ok_q   <= free_any;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.read) begin
			rd_pts_q <= pts_mem[match_idx_q];
		end
		if (mem_we) begin
			pts_mem[mem_addr] <= pts_q;
		end
	end

	always_comb begin
		key_nz     = (key_q != '0);
		local_pre  = key_nz ? (hit_q ? rd_pts_q : '0) : common_pts_q;
		sstart_eff = (sstart_q == '0) ? seq_q : sstart_q;

		verdict = usgc_pkg::VERDICT_APPLY;
		case (mode_q)
			usgc_pkg::MODE_CHECK_PTS: begin
				if (local_pre == '0 || 32'(local_pre + cnt_q) == pts_q) begin
					verdict = usgc_pkg::VERDICT_APPLY;
				end else if (pts_q <= local_pre) begin
					verdict = usgc_pkg::VERDICT_DUPLICATE;
				end else begin
					verdict = usgc_pkg::VERDICT_GAP;
				end
			end
			usgc_pkg::MODE_CHECK_SEQ: begin
				if (seq_q == '0) begin
					verdict = usgc_pkg::VERDICT_IGNORE;
				end else if (32'(common_seq_q + 32'sd1) == sstart_eff) begin
					verdict = usgc_pkg::VERDICT_APPLY;
				end else if (sstart_eff <= common_seq_q) begin
					verdict = usgc_pkg::VERDICT_DUPLICATE;
				end else begin
					verdict = usgc_pkg::VERDICT_GAP;
				end
			end
			default: begin
				verdict = usgc_pkg::VERDICT_APPLY;
			end
		endcase

		store_req = key_nz && ((mode_q == usgc_pkg::MODE_SET_CHAN) ||
			(mode_q == usgc_pkg::MODE_ADV_PTS && pts_q > local_pre));
		store_ok  = store_req && (hit_q || free_ok_q);
		full      = store_req && !store_ok;
		mem_we    = cmd.exec && store_ok;
		mem_addr  = hit_q ? match_idx_q : free_idx_q;
		forget_hit = (mode_q == usgc_pkg::MODE_FORGET) && hit_q;

		common_pts_d   = common_pts_q;
		common_seq_d   = common_seq_q;
		last_date_d    = last_date_q;
		counters_set_d = counters_set_q;
		case (mode_q)
			usgc_pkg::MODE_ADV_PTS: begin
				if (!key_nz && pts_q > local_pre) begin
					common_pts_d = pts_q;
				end
			end
			usgc_pkg::MODE_SET_CHAN: begin
				if (!key_nz) begin
					common_pts_d   = pts_q;
					counters_set_d = 1'b1;
				end
			end
			usgc_pkg::MODE_ADV_SEQ: begin
				if (seq_q > common_seq_q) begin
					common_seq_d = seq_q;
				end
				if (date_q > last_date_q) begin
					last_date_d = date_q;
				end
			end
			usgc_pkg::MODE_RESET: begin
				common_pts_d   = pts_q;
				common_seq_d   = seq_q;
				last_date_d    = date_q;
				counters_set_d = 1'b1;
			end
			usgc_pkg::MODE_CLEAR: begin
				common_pts_d   = '0;
				common_seq_d   = '0;
				last_date_d    = '0;
				counters_set_d = 1'b0;
			end
			default: begin
				counters_set_d = counters_set_q;
			end
		endcase

		if (!key_nz) begin
			local_post = common_pts_d;
			known_post = 1'b0;
		end else if (mode_q == usgc_pkg::MODE_CLEAR || forget_hit || full) begin
			local_post = '0;
			known_post = 1'b0;
		end else if (store_ok) begin
			local_post = pts_q;
			known_post = 1'b1;
		end else begin
			local_post = local_pre;
			known_post = hit_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			common_pts_q   <= '0;
			common_seq_q   <= '0;
			last_date_q    <= '0;
			counters_set_q <= 1'b0;
			used_q         <= '0;
		end else if (cmd.exec) begin
			common_pts_q   <= common_pts_d;
			common_seq_q   <= common_seq_d;
			last_date_q    <= last_date_d;
			counters_set_q <= counters_set_d;
			if (mode_q == usgc_pkg::MODE_CLEAR) begin
				used_q <= '0;
			end else if (forget_hit) begin
				used_q[match_idx_q] <= 1'b0;
			end else if (store_ok && !hit_q) begin
				used_q[free_idx_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && store_ok && !hit_q) begin
			key_tab_q[free_idx_q] <= key_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			verdict_q     <= verdict;
			local_q       <= local_post;
			known_q       <= known_post;
			state_valid_q <= counters_set_d;
			full_q        <= full;
		end
	end

	assign status.out_free = !out_valid_q || rsp.ready;

	assign rsp.valid       = out_valid_q;
	assign rsp.verdict     = verdict_q;
	assign rsp.local_pts   = local_q;
	assign rsp.known       = known_q;
	assign rsp.state_valid = state_valid_q;
	assign rsp.table_full  = full_q;

endmodule
